### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the buffer descriptor address generator.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hw/rtl/bdag_pkg.sv
`timescale 1ns / 1ps
// Package for the buffer descriptor address generator: payload structs,
// configuration view, internal stage records and register index codes.
package bdag_pkg;

  localparam int unsigned MAX_ELEMENTS = 4;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUFFER_STRIDE     = 3'd0,
    CFG_RECORD_COUNT      = 3'd1,
    CFG_SWIZZLE_ENABLE    = 3'd2,
    CFG_ELEMENT_SIZE_CODE = 3'd3,
    CFG_INDEX_STRIDE_CODE = 3'd4
  } cfg_index_t;

  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd2
  } access_size_t;

  typedef struct packed {
    logic [1:0]  access_size;
    logic [2:0]  element_count;
    logic        indexed;
    logic        scalar_read;
    logic        lane_active;
    logic [31:0] record_index;
    logic [31:0] vector_offset;
    logic [31:0] scalar_offset;
    logic [11:0] immediate_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  element_number;
    logic [31:0] byte_offset;
    logic        bounds_ok;
    logic        access_enable;
    logic        last_element;
  } out_item_t;

  // Descriptor registers plus the derived raw-check limit.
  typedef struct packed {
    logic [13:0] buffer_stride;
    logic [31:0] record_count;
    logic        swizzle_enable;
    logic [1:0]  element_size_code;
    logic [1:0]  index_stride_code;
    logic [31:0] limit;
  } cfg_t;

  // Per-access record after the multiplier stage.
  typedef struct packed {
    logic [1:0]  last_num;
    logic [2:0]  bytes;
    logic [31:0] idx;
    logic [31:0] lin_prod;
    logic [31:0] msb_prod;
    logic [31:0] base_off;
    logic [31:0] soff;
    logic        structured;
    logic        swz_sel;
    logic        active;
  } work_t;

endpackage

### hw/rtl/bdag_cfg_regs.sv
`timescale 1ns / 1ps
// Descriptor register file and registered raw-check limit.
// Depends on bdag_pkg.
module bdag_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [bdag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bdag_pkg::CFG_DATA_W-1:0] cfg_data,
  output bdag_pkg::cfg_t                  cfg
);

  logic [13:0] buffer_stride;
  logic [31:0] record_count;
  logic        swizzle_enable;
  logic [1:0]  element_size_code;
  logic [1:0]  index_stride_code;
  logic [31:0] limit;
  logic [31:0] limit_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_stride     <= '0;
      record_count      <= '0;
      swizzle_enable    <= 1'b0;
      element_size_code <= '0;
      index_stride_code <= '0;
    end else if (cfg_write) begin
      unique case (bdag_pkg::cfg_index_t'(cfg_index))
        bdag_pkg::CFG_BUFFER_STRIDE:     buffer_stride     <= cfg_data[13:0];
        bdag_pkg::CFG_RECORD_COUNT:      record_count      <= cfg_data[31:0];
        bdag_pkg::CFG_SWIZZLE_ENABLE:    swizzle_enable    <= cfg_data[0];
        bdag_pkg::CFG_ELEMENT_SIZE_CODE: element_size_code <= cfg_data[1:0];
        bdag_pkg::CFG_INDEX_STRIDE_CODE: index_stride_code <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // stride of zero means raw bytes: limit is the record count itself
  always_comb begin
    if (buffer_stride != '0) begin
      limit_next = {18'b0, buffer_stride} * record_count;
    end else begin
      limit_next = record_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= '0;
    end else begin
      limit <= limit_next;
    end
  end

  assign cfg.buffer_stride     = buffer_stride;
  assign cfg.record_count      = record_count;
  assign cfg.swizzle_enable    = swizzle_enable;
  assign cfg.element_size_code = element_size_code;
  assign cfg.index_stride_code = index_stride_code;
  assign cfg.limit             = limit;

endmodule

### hw/rtl/bdag_prep.sv
`timescale 1ns / 1ps
// Input register and per-access multiplier stage.
// Depends on bdag_pkg.
module bdag_prep (
  input  logic               clk,
  input  logic               rst,
  input  bdag_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  bdag_pkg::in_item_t in_data,
  output logic               work_valid,
  input  logic               work_ready,
  output bdag_pkg::work_t    work
);

  logic               s1_valid;
  bdag_pkg::in_item_t s1;
  logic               s2_valid;
  bdag_pkg::work_t    s2;
  bdag_pkg::work_t    s2_next;
  logic               s2_free;
  logic               s1_move;
  logic [2:0]         count;
  logic [2:0]         il;
  logic [31:0]        idx;
  logic               scalar;

  assign s2_free  = !s2_valid || work_ready;
  assign s1_move  = s1_valid && s2_free;
  assign in_ready = !s1_valid || s1_move;

  always_comb begin
    scalar = s1.scalar_read;
    idx    = (s1.indexed && !scalar) ? s1.record_index : '0;
    il     = {1'b0, cfg.index_stride_code} + 3'd3;

    count = s1.element_count;
    if (count == 3'd0) begin
      count = 3'd1;
    end
    if (count > 3'(bdag_pkg::MAX_ELEMENTS)) begin
      count = 3'(bdag_pkg::MAX_ELEMENTS);
    end

    s2_next.last_num = 2'(count - 3'd1);
    unique case (s1.access_size)
      bdag_pkg::SIZE_BYTE: s2_next.bytes = 3'd1;
      bdag_pkg::SIZE_HALF: s2_next.bytes = 3'd2;
      default:             s2_next.bytes = 3'd4;
    endcase
    s2_next.idx        = idx;
    s2_next.lin_prod   = idx * {18'b0, cfg.buffer_stride};
    s2_next.msb_prod   = (idx >> il) * {18'b0, cfg.buffer_stride};
    s2_next.base_off   = s1.vector_offset + {20'b0, s1.immediate_offset};
    s2_next.soff       = scalar ? '0 : s1.scalar_offset;
    s2_next.structured = s1.indexed && !scalar && (cfg.buffer_stride != '0);
    s2_next.swz_sel    = !scalar && cfg.swizzle_enable;
    s2_next.active     = scalar || s1.lane_active;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1 <= in_data;
    end
    if (s1_move) begin
      s2 <= s2_next;
    end
  end

  assign work_valid = s2_valid;
  assign work       = s2;

endmodule

### hw/rtl/bdag_elem.sv
`timescale 1ns / 1ps
// Element sequencer: one element per cycle while the output is not stalled, offset,
// swizzle, bounds check, and the result register. Depends on bdag_pkg.
module bdag_elem (
  input  logic                clk,
  input  logic                rst,
  input  bdag_pkg::cfg_t      cfg,
  input  logic                work_valid,
  output logic                work_ready,
  input  bdag_pkg::work_t     work,
  output logic                out_valid,
  input  logic                out_ready,
  output bdag_pkg::out_item_t out_data
);

  logic                s3_valid;
  logic [1:0]          elem_num;
  logic [31:0]         off;
  logic [31:0]         lin_prod;
  logic [31:0]         swz_const;
  logic [31:0]         soff;
  logic [2:0]          bytes;
  logic [1:0]          last_num;
  logic                structured;
  logic                idx_ok;
  logic                swz_sel;
  logic                active;

  logic                out_free;
  logic                adv;
  logic                s3_last;
  logic                s3_free;
  logic [2:0]          el;
  logic [2:0]          il;
  logic [3:0]          il_el;
  logic [31:0]         emask;
  logic [31:0]         imask;
  logic [31:0]         bytes32;
  logic [31:0]         swz;
  logic [31:0]         rec;
  logic                ok;
  bdag_pkg::out_item_t res;

  assign out_free   = !out_valid || out_ready;
  assign adv        = s3_valid && out_free;
  assign s3_last    = elem_num == last_num;
  assign s3_free    = !s3_valid || (adv && s3_last);
  assign work_ready = s3_free;

  always_comb begin
    el      = {1'b0, cfg.element_size_code} + 3'd1;
    il      = {1'b0, cfg.index_stride_code} + 3'd3;
    il_el   = {1'b0, il} + {1'b0, el};
    emask   = (32'd1 << el) - 32'd1;
    imask   = (32'd1 << il) - 32'd1;
    bytes32 = {29'b0, bytes};
    // high part and low part of the offset occupy disjoint bit fields
    swz     = swz_const + (((off >> el) << il_el) | (off & emask));
    rec     = swz_sel ? swz : (lin_prod + off);
    if (structured) begin
      ok = idx_ok && ((off + bytes32) <= {18'b0, cfg.buffer_stride});
    end else begin
      ok = (rec + bytes32) <= cfg.limit;
    end
    res.element_number = elem_num;
    res.byte_offset    = rec + soff;
    res.bounds_ok      = ok;
    res.access_enable  = active && ok;
    res.last_element   = s3_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s3_free) begin
        s3_valid <= work_valid;
      end
      if (out_free) begin
        out_valid <= s3_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_free && work_valid) begin
      elem_num   <= '0;
      off        <= work.base_off;
      lin_prod   <= work.lin_prod;
      swz_const  <= (work.msb_prod << il) + ((work.idx & imask) << el);
      soff       <= work.soff;
      bytes      <= work.bytes;
      last_num   <= work.last_num;
      structured <= work.structured;
      idx_ok     <= work.idx < cfg.record_count;
      swz_sel    <= work.swz_sel;
      active     <= work.active;
    end else if (adv) begin
      elem_num <= elem_num + 2'd1;
      off      <= off + bytes32;
    end
    if (adv) begin
      out_data <= res;
    end
  end

endmodule

### hw/rtl/buffer_descriptor_address_gen.sv
`timescale 1ns / 1ps
// Buffer descriptor address generator: one access in, one result per element.
// Path: input register, multiplier stage, element sequencer, result register.
// Throughput: one result per cycle while out_ready does not stall the output; an
// access of 1 to 4 elements holds the element sequencer until its last element leaves.
// Reset (rst, synchronous): empties all stages, clears descriptor registers.
`include "assert_macros.svh"
module buffer_descriptor_address_gen (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [bdag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bdag_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  bdag_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output bdag_pkg::out_item_t             out_data
);

  bdag_pkg::cfg_t  cfg;
  logic            work_valid;
  logic            work_ready;
  bdag_pkg::work_t work;

  bdag_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bdag_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .work_valid (work_valid),
    .work_ready (work_ready),
    .work       (work)
  );

  bdag_elem u_elem (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .work_valid (work_valid),
    .work_ready (work_ready),
    .work       (work),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // remaining elements of an access follow without a gap, numbered in order
  `ASSERT_NEXT(a_elem_seq, clk, rst, out_valid && out_ready && !out_data.last_element, out_valid && (out_data.element_number == $past(out_data.element_number) + 2'd1))
  // input stalls only when the multiplier stage is full
  `ASSERT_IMPLY(a_stall_cause, clk, rst, !in_ready, work_valid)
  `ASSERT_IMPLY(a_enable_range, clk, rst, out_valid && out_data.access_enable, out_data.bounds_ok)

endmodule

### verif/tb_buffer_descriptor_address_gen.sv
`timescale 1ns / 1ps
// Self-checking testbench for buffer_descriptor_address_gen: directed and random
// accesses under several descriptor settings, checked per element against a local predictor.
// Depends on bdag_pkg and the buffer_descriptor_address_gen RTL.
module tb_buffer_descriptor_address_gen;

  localparam logic [1:0] SIZE_UNDEF = 2'd3;

  logic                            clk;
  logic                            rst;
  logic                            cfg_write;
  bdag_pkg::cfg_index_t            cfg_index;
  logic [bdag_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            in_valid;
  logic                            in_ready;
  bdag_pkg::in_item_t              in_data;
  logic                            out_valid;
  logic                            out_ready;
  bdag_pkg::out_item_t             out_data;

  // descriptor copy for prediction
  logic [13:0] desc_stride;
  logic [31:0] desc_count;
  logic        desc_swizzle;
  logic [1:0]  desc_esize;
  logic [1:0]  desc_istride;

  bdag_pkg::out_item_t element_results_due[$];
  int        errors;
  int        accesses_sent;
  int        elements_seen;
  int        descriptors_loaded;
  int        send_gap_pct;
  int        stall_pct;

  buffer_descriptor_address_gen dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("timeout: %0d element results still outstanding", element_results_due.size());
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic void compute_element_results(input bdag_pkg::in_item_t a);
    logic [31:0] bytes, idx, soff, off, linear, swz, rec, limit, base_off;
    logic [31:0] idx_msb, idx_lsb, emask, imask, end_sum, msb_prod;
    int unsigned count, el, il;
    logic        active, structured, ok;
    bdag_pkg::out_item_t r;
    case (a.access_size)
      bdag_pkg::SIZE_BYTE: bytes = 32'd1;
      bdag_pkg::SIZE_HALF: bytes = 32'd2;
      default:             bytes = 32'd4;
    endcase
    count = a.element_count;
    if (count < 1) count = 1;
    if (count > bdag_pkg::MAX_ELEMENTS) count = bdag_pkg::MAX_ELEMENTS;
    idx        = (a.indexed && !a.scalar_read) ? a.record_index : 32'd0;
    soff       = a.scalar_read ? 32'd0 : a.scalar_offset;
    active     = a.scalar_read || a.lane_active;
    el         = desc_esize + 1;
    il         = desc_istride + 3;
    emask      = (32'd1 << el) - 32'd1;
    imask      = (32'd1 << il) - 32'd1;
    idx_msb    = idx >> il;
    idx_lsb    = idx & imask;
    limit      = (desc_stride != 0) ? 32'({18'd0, desc_stride} * desc_count) : desc_count;
    base_off   = a.vector_offset + {20'd0, a.immediate_offset};
    structured = a.indexed && !a.scalar_read && desc_stride != 0;
    for (int unsigned e = 0; e < count; e++) begin
      off      = base_off + 32'(e) * bytes;
      linear   = 32'(idx * {18'd0, desc_stride}) + off;
      msb_prod = 32'(idx_msb * {18'd0, desc_stride});
      swz      = (msb_prod << il) + ((off >> el) << (il + el)) + (idx_lsb << el) + (off & emask);
      rec      = (!a.scalar_read && desc_swizzle) ? swz : linear;
      if (structured) begin
        end_sum = off + bytes;
        ok = (idx < desc_count) && (end_sum <= {18'd0, desc_stride});
      end else begin
        end_sum = rec + bytes;
        ok = end_sum <= limit;
      end
      r.element_number = 2'(e);
      r.byte_offset    = rec + soff;
      r.bounds_ok      = ok;
      r.access_enable  = active && ok;
      r.last_element   = (e + 1 == count);
      element_results_due.insert(element_results_due.size(), r);
    end
  endfunction

  function automatic bdag_pkg::in_item_t make_access(
      input logic [1:0] size, input logic [2:0] cnt,
      input logic indexed, input logic scalar,
      input logic lane, input logic [31:0] idx,
      input logic [31:0] voff, input logic [31:0] soff,
      input logic [11:0] imm);
    bdag_pkg::in_item_t a;
    a.access_size      = size;
    a.element_count    = cnt;
    a.indexed          = indexed;
    a.scalar_read      = scalar;
    a.lane_active      = lane;
    a.record_index     = idx;
    a.vector_offset    = voff;
    a.scalar_offset    = soff;
    a.immediate_offset = imm;
    return a;
  endfunction

  // Mostly accesses near the record and raw limits, the rest fully random.
  function automatic bdag_pkg::in_item_t random_access();
    bdag_pkg::in_item_t a;
    logic [31:0]        lim;
    lim = (desc_stride != 0) ? 32'({18'd0, desc_stride} * desc_count) : desc_count;
    a.access_size   = 2'($urandom_range(3));
    a.element_count = ($urandom_range(9) < 8) ? 3'($urandom_range(1, bdag_pkg::MAX_ELEMENTS))
                                              : 3'($urandom_range(7));
    a.indexed       = 1'($urandom_range(1));
    a.scalar_read   = ($urandom_range(4) == 0);
    a.lane_active   = ($urandom_range(5) != 0);
    if ($urandom_range(9) < 7) begin
      a.record_index = $urandom_range(1) ? 32'(desc_count + $urandom_range(3) - 2)
                                         : 32'($urandom_range(40));
      if (a.indexed && desc_stride != 0)
        a.vector_offset = $urandom_range(desc_stride + 4);
      else
        a.vector_offset = $urandom_range(1) ? 32'(lim - $urandom_range(24))
                                            : 32'($urandom_range(64));
      a.scalar_offset    = $urandom_range(1) ? 32'($urandom_range(255)) : $urandom;
      a.immediate_offset = 12'($urandom_range(3));
    end else begin
      a.record_index     = $urandom;
      a.vector_offset    = $urandom;
      a.scalar_offset    = $urandom;
      a.immediate_offset = 12'($urandom_range(4095));
    end
    return a;
  endfunction

  task automatic send_access(input bdag_pkg::in_item_t a);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid <= 1'b1;
    in_data  <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    compute_element_results(a);
    accesses_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (element_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic load_descriptor(input logic [13:0] stride, input logic [31:0] count,
                                 input logic swz, input logic [1:0] esize,
                                 input logic [1:0] istride);
    cfg_write <= 1'b1;
    cfg_index <= bdag_pkg::CFG_BUFFER_STRIDE;     cfg_data <= {18'd0, stride};  @(posedge clk);
    cfg_index <= bdag_pkg::CFG_RECORD_COUNT;      cfg_data <= count;            @(posedge clk);
    cfg_index <= bdag_pkg::CFG_SWIZZLE_ENABLE;    cfg_data <= {31'd0, swz};     @(posedge clk);
    cfg_index <= bdag_pkg::CFG_ELEMENT_SIZE_CODE; cfg_data <= {30'd0, esize};   @(posedge clk);
    cfg_index <= bdag_pkg::CFG_INDEX_STRIDE_CODE; cfg_data <= {30'd0, istride}; @(posedge clk);
    cfg_write <= 1'b0;
    desc_stride  = stride;
    desc_count   = count;
    desc_swizzle = swz;
    desc_esize   = esize;
    desc_istride = istride;
    descriptors_loaded++;
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    bdag_pkg::out_item_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      elements_seen++;
      if (element_results_due.size() == 0) begin
        report_mismatch($sformatf("unexpected element result %p", out_data));
      end else begin
        want = element_results_due.pop_front();
        if (out_data.element_number !== want.element_number)
          report_mismatch($sformatf("element_number got %0d want %0d",
                                    out_data.element_number, want.element_number));
        if (out_data.byte_offset !== want.byte_offset)
          report_mismatch($sformatf("byte_offset got %h want %h (element %0d)",
                                    out_data.byte_offset, want.byte_offset,
                                    want.element_number));
        if (out_data.bounds_ok !== want.bounds_ok)
          report_mismatch($sformatf("bounds_ok got %b want %b (element %0d)",
                                    out_data.bounds_ok, want.bounds_ok, want.element_number));
        if (out_data.access_enable !== want.access_enable)
          report_mismatch($sformatf("access_enable got %b want %b (element %0d)",
                                    out_data.access_enable, want.access_enable,
                                    want.element_number));
        if (out_data.last_element !== want.last_element)
          report_mismatch($sformatf("last_element got %b want %b (element %0d)",
                                    out_data.last_element, want.last_element,
                                    want.element_number));
      end
    end
  end

  // Reset descriptor: zero limit, so every raw access is out of range.
  task automatic test_reset_descriptor();
    send_access(make_access(bdag_pkg::SIZE_BYTE, 3'd1, 1'b0, 1'b0, 1'b1, 32'd0, 32'd0,
                            32'd0, 12'd0));
    send_access(make_access(bdag_pkg::SIZE_WORD, 3'd4, 1'b1, 1'b1, 1'b0, 32'd5, 32'd8,
                            32'h10, 12'd0));
    drain_results();
  endtask

  task automatic test_linear_bounds();
    load_descriptor(14'd16, 32'd4, 1'b0, 2'd0, 2'd0);
    send_access(make_access(bdag_pkg::SIZE_WORD, 3'd1, 1'b1, 1'b0, 1'b1, 32'd3, 32'd12,
                            32'd0, 12'd0));
    send_access(make_access(bdag_pkg::SIZE_WORD, 3'd2, 1'b1, 1'b0, 1'b1, 32'd3, 32'd12,
                            32'd7, 12'd0));
    send_access(make_access(bdag_pkg::SIZE_HALF, 3'd1, 1'b1, 1'b0, 1'b1, 32'd4, 32'd0,
                            32'd0, 12'd0));
    send_access(make_access(bdag_pkg::SIZE_HALF, 3'd3, 1'b1, 1'b0, 1'b0, 32'd1, 32'd2,
                            32'd0, 12'd0));
    send_access(make_access(bdag_pkg::SIZE_WORD, 3'd1, 1'b0, 1'b0, 1'b1, 32'd9, 32'd60,
                            32'd0, 12'd0));
    send_access(make_access(bdag_pkg::SIZE_WORD, 3'd1, 1'b0, 1'b0, 1'b1, 32'd0, 32'd61,
                            32'd0, 12'd0));
    send_access(make_access(bdag_pkg::SIZE_BYTE, 3'd0, 1'b1, 1'b0, 1'b1, 32'd2, 32'd5,
                            32'd0, 12'd0));
    send_access(make_access(bdag_pkg::SIZE_BYTE, 3'd7, 1'b1, 1'b0, 1'b1, 32'd2, 32'd5,
                            32'd0, 12'd0));
    send_access(make_access(SIZE_UNDEF, 3'd2, 1'b1, 1'b0, 1'b1, 32'd0, 32'd4, 32'd0, 12'd0));
    send_access(make_access(bdag_pkg::SIZE_BYTE, 3'd1, 1'b0, 1'b0, 1'b1, 32'd0, 32'd0,
                            32'd0, 12'hfff));
    send_access(make_access(bdag_pkg::SIZE_WORD, 3'd4, 1'b1, 1'b1, 1'b0, 32'hffff_ffff, 32'd4,
                            32'hffff_ffff, 12'd0));
    send_access(make_access(bdag_pkg::SIZE_BYTE, 3'd2, 1'b0, 1'b0, 1'b1, 32'd0, 32'hffff_ffff,
                            32'h8000_0000, 12'd0));
    send_access(make_access(bdag_pkg::SIZE_HALF, 3'd1, 1'b1, 1'b0, 1'b1, 32'hffff_ffff, 32'd0,
                            32'd0, 12'd0));
    drain_results();
  endtask

  task automatic test_swizzle_extremes();
    load_descriptor(14'h3fff, 32'hffff_ffff, 1'b1, 2'd3, 2'd3);
    send_access(make_access(bdag_pkg::SIZE_WORD, 3'd4, 1'b1, 1'b0, 1'b1, 32'hffff_ffff,
                            32'h0001_2345, 32'h0000_1000, 12'd7));
    send_access(make_access(bdag_pkg::SIZE_HALF, 3'd2, 1'b0, 1'b0, 1'b1, 32'd77, 32'd300,
                            32'd0, 12'd0));
    send_access(make_access(bdag_pkg::SIZE_WORD, 3'd1, 1'b1, 1'b1, 1'b1, 32'd123, 32'd40,
                            32'd9, 12'd0));
    drain_results();
    load_descriptor(14'd24, 32'd100, 1'b1, 2'd0, 2'd0);
    send_access(make_access(bdag_pkg::SIZE_BYTE, 3'd4, 1'b1, 1'b0, 1'b1, 32'd13, 32'd3,
                            32'd0, 12'd0));
    send_access(make_access(bdag_pkg::SIZE_WORD, 3'd3, 1'b1, 1'b0, 1'b1, 32'd99, 32'd16,
                            32'd5, 12'd0));
    drain_results();
  endtask

  task automatic test_raw_byte_buffer();
    load_descriptor(14'd0, 32'd100, 1'b0, 2'd1, 2'd2);
    send_access(make_access(bdag_pkg::SIZE_WORD, 3'd1, 1'b0, 1'b0, 1'b1, 32'd0, 32'd96,
                            32'd0, 12'd0));
    send_access(make_access(bdag_pkg::SIZE_WORD, 3'd1, 1'b1, 1'b0, 1'b1, 32'd50, 32'd97,
                            32'd0, 12'd0));
    drain_results();
  endtask

  task automatic test_random_traffic();
    int gaps[4]   = '{0, 61, 0, 16};
    int stalls[4] = '{0, 0, 61, 16};
    logic [13:0] stride;
    logic [31:0] count;
    for (int p = 0; p < 4; p++) begin
      send_gap_pct = gaps[p];
      stall_pct    = stalls[p];
      for (int d = 0; d < 3; d++) begin
        case ($urandom_range(3))
          0:       stride = 14'd0;
          1:       stride = 14'h3fff;
          2:       stride = 14'($urandom_range(1, 64));
          default: stride = 14'($urandom_range(16383));
        endcase
        case ($urandom_range(3))
          0:       count = 32'd0;
          1:       count = 32'hffff_ffff;
          2:       count = $urandom_range(1, 200);
          default: count = $urandom;
        endcase
        load_descriptor(stride, count, 1'($urandom_range(1)), 2'($urandom_range(3)),
                        2'($urandom_range(3)));
        repeat (24) send_access(random_access());
        drain_results();
      end
    end
    send_gap_pct = 0;
    stall_pct    = 0;
  endtask

  initial begin
    rst                = 1'b1;
    cfg_write          = 1'b0;
    cfg_index          = bdag_pkg::CFG_BUFFER_STRIDE;
    cfg_data           = '0;
    in_valid           = 1'b0;
    in_data            = '0;
    out_ready          = 1'b0;
    desc_stride        = '0;
    desc_count         = '0;
    desc_swizzle       = 1'b0;
    desc_esize         = '0;
    desc_istride       = '0;
    errors             = 0;
    accesses_sent      = 0;
    elements_seen      = 0;
    descriptors_loaded = 0;
    send_gap_pct       = 0;
    stall_pct          = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_descriptor();
    test_linear_bounds();
    test_swizzle_extremes();
    test_raw_byte_buffer();
    test_random_traffic();

    drain_results();
    repeat (10) @(posedge clk);
    if (element_results_due.size() != 0)
      report_mismatch($sformatf("%0d element results never arrived",
                                element_results_due.size()));
    $display("Covered %0d accesses and %0d element transfers over %0d descriptor settings,",
             accesses_sent, elements_seen, descriptors_loaded);
    $display("linear, swizzled and raw bounds, with four sender/receiver throttle mixes.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
